### hdl/lix_pkg.sv
// Shared types for the line intersection pipeline.
package lix_pkg;

  typedef enum logic [1:0] {
    ST_FOUND     = 2'd0,
    ST_PARALLEL  = 2'd1,
    ST_SATURATED = 2'd2
  } status_t;

  // Per-item control that travels alongside the data in every stage.
  typedef struct packed {
    logic valid;
    logic den_zero;
    logic neg;
  } ctl_t;

endpackage

### hdl/lix_front.sv
// Front stages: direction differences, cross products, denominator and numerator magnitudes.
module lix_front #(
  parameter int W = 32
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  logic signed [W-1:0]  a_start_x,
  input  logic signed [W-1:0]  a_start_y,
  input  logic signed [W-1:0]  a_end_x,
  input  logic signed [W-1:0]  a_end_y,
  input  logic signed [W-1:0]  b_start_x,
  input  logic signed [W-1:0]  b_start_y,
  input  logic signed [W-1:0]  b_end_x,
  input  logic signed [W-1:0]  b_end_y,
  output lix_pkg::ctl_t        ctl,
  output logic [2*W+1:0]       den_mag,
  output logic [2*W+1:0]       num_mag,
  output logic [W:0]           dx_mag,
  output logic                 dx_neg,
  output logic [W:0]           dy_mag,
  output logic                 dy_neg,
  output logic signed [W-1:0]  ax0,
  output logic signed [W-1:0]  ay0
);

  // Stage A: differences.
  logic                va;
  logic signed [W:0]   dax_a, day_a, dbx_a, dby_a, cx_a, cy_a;
  logic signed [W-1:0] sx_a, sy_a;

  // Stage B: products.
  logic                  vb;
  logic signed [2*W+1:0] p_aybx, p_axby, p_bycx, p_bxcy;
  logic signed [W:0]     dax_b, day_b;
  logic signed [W-1:0]   sx_b, sy_b;

  // Stage C: denominator and numerator.
  logic                  vc;
  logic signed [2*W+2:0] den, num;
  logic signed [W:0]     dax_c, day_c;
  logic signed [W-1:0]   sx_c, sy_c;

  logic [2*W+2:0] den_abs, num_abs;
  logic [W:0]     dax_abs, day_abs;

  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0;
      vb <= 1'b0;
      vc <= 1'b0;
    end else begin
      va <= in_valid;
      vb <= va;
      vc <= vb;
    end
  end

  always_ff @(posedge clk) begin
    dax_a <= {a_end_x[W-1], a_end_x} - {a_start_x[W-1], a_start_x};
    day_a <= {a_end_y[W-1], a_end_y} - {a_start_y[W-1], a_start_y};
    dbx_a <= {b_start_x[W-1], b_start_x} - {b_end_x[W-1], b_end_x};
    dby_a <= {b_start_y[W-1], b_start_y} - {b_end_y[W-1], b_end_y};
    cx_a  <= {a_start_x[W-1], a_start_x} - {b_start_x[W-1], b_start_x};
    cy_a  <= {a_start_y[W-1], a_start_y} - {b_start_y[W-1], b_start_y};
    sx_a  <= a_start_x;
    sy_a  <= a_start_y;

    p_aybx <= (2*W+2)'(day_a) * (2*W+2)'(dbx_a);
    p_axby <= (2*W+2)'(dax_a) * (2*W+2)'(dby_a);
    p_bycx <= (2*W+2)'(dby_a) * (2*W+2)'(cx_a);
    p_bxcy <= (2*W+2)'(dbx_a) * (2*W+2)'(cy_a);
    dax_b  <= dax_a;
    day_b  <= day_a;
    sx_b   <= sx_a;
    sy_b   <= sy_a;

    den   <= {p_aybx[2*W+1], p_aybx} - {p_axby[2*W+1], p_axby};
    num   <= {p_bycx[2*W+1], p_bycx} - {p_bxcy[2*W+1], p_bxcy};
    dax_c <= dax_b;
    day_c <= day_b;
    sx_c  <= sx_b;
    sy_c  <= sy_b;
  end

  assign den_abs = den[2*W+2] ? (~den + 1'b1) : den;
  assign num_abs = num[2*W+2] ? (~num + 1'b1) : num;
  assign dax_abs = dax_c[W] ? (~dax_c + 1'b1) : dax_c;
  assign day_abs = day_c[W] ? (~day_c + 1'b1) : day_c;

  // Stage D: magnitudes and signs. Both magnitudes stay below 2**(2W+1).
  always_ff @(posedge clk) begin
    if (rst) begin
      ctl <= '0;
    end else begin
      ctl <= '{valid: vc, den_zero: (den == '0), neg: den[2*W+2] ^ num[2*W+2]};
    end
  end

  always_ff @(posedge clk) begin
    den_mag <= den_abs[2*W+1:0];
    num_mag <= num_abs[2*W+1:0];
    dx_mag  <= dax_abs;
    dx_neg  <= dax_c[W];
    dy_mag  <= day_abs;
    dy_neg  <= day_c[W];
    ax0     <= sx_c;
    ay0     <= sy_c;
  end

endmodule

### hdl/lix_scale.sv
// Two-stage multiply of the numerator magnitude by one direction magnitude.
module lix_scale #(
  parameter int W = 32
) (
  input  logic                 clk,
  input  logic                 rst,
  input  lix_pkg::ctl_t        ctl_in,
  input  logic [2*W+1:0]       num_mag,
  input  logic [W:0]           dir_mag,
  input  logic                 dir_neg,
  input  logic [2*W+1:0]       den_mag,
  input  logic signed [W-1:0]  start,
  output lix_pkg::ctl_t        ctl_out,
  output logic [3*W+1:0]       p_mag,
  output logic [2*W+1:0]       den_out,
  output logic signed [W-1:0]  start_out
);

  lix_pkg::ctl_t       ctl_e;
  logic [2*W+1:0]      pp_lo, pp_hi;
  logic [2*W+1:0]      den_e;
  logic signed [W-1:0] start_e;
  logic [3*W+2:0]      p_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_e   <= '0;
      ctl_out <= '0;
    end else begin
      ctl_e   <= '{valid: ctl_in.valid, den_zero: ctl_in.den_zero,
                   neg: ctl_in.neg ^ dir_neg};
      ctl_out <= ctl_e;
    end
  end

  // The numerator is split into two halves of W+1 bits each.
  always_ff @(posedge clk) begin
    pp_lo   <= (2*W+2)'(num_mag[W:0]) * (2*W+2)'(dir_mag);
    pp_hi   <= (2*W+2)'(num_mag[2*W+1:W+1]) * (2*W+2)'(dir_mag);
    den_e   <= den_mag;
    start_e <= start;
  end

  assign p_full = {pp_hi, {(W+1){1'b0}}} + {{(W+1){1'b0}}, pp_lo};

  // The product stays below 2**(3W+1), so the top bit of the sum is always zero.
  always_ff @(posedge clk) begin
    p_mag     <= p_full[3*W+1:0];
    den_out   <= den_e;
    start_out <= start_e;
  end

endmodule

### hdl/lix_div.sv
// Pipelined restoring divider, one quotient bit per stage, with signed offset and saturation.
module lix_div #(
  parameter int W = 32
) (
  input  logic                 clk,
  input  logic                 rst,
  input  lix_pkg::ctl_t        ctl_in,
  input  logic [3*W+1:0]       p_mag,
  input  logic [2*W+1:0]       den_mag,
  input  logic signed [W-1:0]  start,
  output lix_pkg::ctl_t        ctl_out,
  output logic signed [W-1:0]  coord,
  output logic                 sat
);

  localparam int RW = 3 * W + 2;
  localparam int NS = W + 1;

  localparam logic [W-1:0] CRD_MAX = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0] CRD_MIN = {1'b1, {(W-1){1'b0}}};

  lix_pkg::ctl_t       cs   [0:NS];
  logic [RW-1:0]       rem  [0:NS];
  logic [W:0]          quo  [0:NS];
  logic                ovs  [0:NS];
  logic signed [W-1:0] sts  [0:NS];
  logic [2*W+1:0]      dvs  [0:NS-1];

  logic [W+1:0] sq;
  logic [W+2:0] sum;
  logic         pos_ovf, neg_ovf;

  // A quotient of 2**(W+1) or more always lands outside the coordinate range,
  // so it is flagged here and the bit stages below only need W+1 bits.
  always_ff @(posedge clk) begin
    if (rst) begin
      cs[0] <= '0;
    end else begin
      cs[0] <= ctl_in;
    end
  end

  always_ff @(posedge clk) begin
    rem[0] <= p_mag;
    quo[0] <= '0;
    ovs[0] <= {1'b0, p_mag} >= {den_mag, {(W+1){1'b0}}};
    sts[0] <= start;
    dvs[0] <= den_mag;
  end

  for (genvar i = 0; i < NS; i++) begin : g_step
    localparam int K = W - i;
    logic [RW-1:0] shifted, diff;
    logic          take;

    assign shifted = RW'(dvs[i]) << K;
    assign take    = rem[i] >= shifted;
    assign diff    = rem[i] - shifted;

    always_ff @(posedge clk) begin
      if (rst) begin
        cs[i+1] <= '0;
      end else begin
        cs[i+1] <= cs[i];
      end
    end

    always_ff @(posedge clk) begin
      rem[i+1] <= take ? diff : rem[i];
      quo[i+1] <= {quo[i][W-1:0], take};
      ovs[i+1] <= ovs[i];
      sts[i+1] <= sts[i];
    end

    if (i < NS - 1) begin : g_dv
      always_ff @(posedge clk) begin
        dvs[i+1] <= dvs[i];
      end
    end
  end

  assign sq  = cs[NS].neg ? (~{1'b0, quo[NS]} + 1'b1) : {1'b0, quo[NS]};
  assign sum = {{3{sts[NS][W-1]}}, sts[NS]} + {sq[W+1], sq};

  // The sum fits the coordinate range only if its top four bits agree.
  assign pos_ovf = !sum[W+2] && (sum[W+2:W-1] != 4'b0000);
  assign neg_ovf = sum[W+2] && (sum[W+2:W-1] != 4'b1111);

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_out <= '0;
    end else begin
      ctl_out <= cs[NS];
    end
  end

  always_ff @(posedge clk) begin
    priority if (ovs[NS]) begin
      coord <= cs[NS].neg ? CRD_MIN : CRD_MAX;
    end else if (pos_ovf) begin
      coord <= CRD_MAX;
    end else if (neg_ovf) begin
      coord <= CRD_MIN;
    end else begin
      coord <= sum[W-1:0];
    end
    sat <= ovs[NS] | pos_ovf | neg_ovf;
  end

endmodule

### hdl/line_intersection_2d.sv
// Top level of the pipelined two-line intersection unit.
//
//  Channel   Handshake         Payload
//  -------   ---------------   ------------------------------------------------
//  input     start / busy      a_start_x, a_start_y, a_end_x, a_end_y,
//                              b_start_x, b_start_y, b_end_x, b_end_y
//  result    done (strobe)     status, cross_x, cross_y
//
// One item is accepted every cycle; busy is high only during reset.
// The divider resolves one quotient bit per stage for each coordinate.
// Every item gives exactly one result, held on the ports for one cycle under done.
// Synchronous reset clears all valid bits; items in flight are dropped.
module line_intersection_2d #(
  parameter int COORD_WIDTH = 32
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  output logic                           busy,
  input  logic signed [COORD_WIDTH-1:0]  a_start_x,
  input  logic signed [COORD_WIDTH-1:0]  a_start_y,
  input  logic signed [COORD_WIDTH-1:0]  a_end_x,
  input  logic signed [COORD_WIDTH-1:0]  a_end_y,
  input  logic signed [COORD_WIDTH-1:0]  b_start_x,
  input  logic signed [COORD_WIDTH-1:0]  b_start_y,
  input  logic signed [COORD_WIDTH-1:0]  b_end_x,
  input  logic signed [COORD_WIDTH-1:0]  b_end_y,
  output logic                           done,
  output logic [1:0]                     status,
  output logic signed [COORD_WIDTH-1:0]  cross_x,
  output logic signed [COORD_WIDTH-1:0]  cross_y
);

  localparam int W   = COORD_WIDTH;
  localparam int LAT = COORD_WIDTH + 10;

  localparam logic [W-1:0] CRD_MAX = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0] CRD_MIN = {1'b1, {(W-1){1'b0}}};

  lix_pkg::ctl_t       f_ctl, sx_ctl, sy_ctl, x_ctl, y_ctl;
  logic [2*W+1:0]      den_mag, num_mag, den_x, den_y;
  logic [W:0]          dx_mag, dy_mag;
  logic                dx_neg, dy_neg;
  logic signed [W-1:0] ax0, ay0, sx_start, sy_start;
  logic [3*W+1:0]      px_mag, py_mag;
  logic signed [W-1:0] x_coord, y_coord;
  logic                x_sat, y_sat;

  assign busy = rst;

  lix_front #(.W(W)) u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (start && !busy),
    .a_start_x (a_start_x),
    .a_start_y (a_start_y),
    .a_end_x   (a_end_x),
    .a_end_y   (a_end_y),
    .b_start_x (b_start_x),
    .b_start_y (b_start_y),
    .b_end_x   (b_end_x),
    .b_end_y   (b_end_y),
    .ctl       (f_ctl),
    .den_mag   (den_mag),
    .num_mag   (num_mag),
    .dx_mag    (dx_mag),
    .dx_neg    (dx_neg),
    .dy_mag    (dy_mag),
    .dy_neg    (dy_neg),
    .ax0       (ax0),
    .ay0       (ay0)
  );

  lix_scale #(.W(W)) u_scale_x (
    .clk       (clk),
    .rst       (rst),
    .ctl_in    (f_ctl),
    .num_mag   (num_mag),
    .dir_mag   (dx_mag),
    .dir_neg   (dx_neg),
    .den_mag   (den_mag),
    .start     (ax0),
    .ctl_out   (sx_ctl),
    .p_mag     (px_mag),
    .den_out   (den_x),
    .start_out (sx_start)
  );

  lix_scale #(.W(W)) u_scale_y (
    .clk       (clk),
    .rst       (rst),
    .ctl_in    (f_ctl),
    .num_mag   (num_mag),
    .dir_mag   (dy_mag),
    .dir_neg   (dy_neg),
    .den_mag   (den_mag),
    .start     (ay0),
    .ctl_out   (sy_ctl),
    .p_mag     (py_mag),
    .den_out   (den_y),
    .start_out (sy_start)
  );

  lix_div #(.W(W)) u_div_x (
    .clk     (clk),
    .rst     (rst),
    .ctl_in  (sx_ctl),
    .p_mag   (px_mag),
    .den_mag (den_x),
    .start   (sx_start),
    .ctl_out (x_ctl),
    .coord   (x_coord),
    .sat     (x_sat)
  );

  lix_div #(.W(W)) u_div_y (
    .clk     (clk),
    .rst     (rst),
    .ctl_in  (sy_ctl),
    .p_mag   (py_mag),
    .den_mag (den_y),
    .start   (sy_start),
    .ctl_out (y_ctl),
    .coord   (y_coord),
    .sat     (y_sat)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= x_ctl.valid;
    end
  end

  always_ff @(posedge clk) begin
    priority if (x_ctl.den_zero) begin
      status  <= lix_pkg::ST_PARALLEL;
      cross_x <= '0;
      cross_y <= '0;
    end else if (x_sat || y_sat) begin
      status  <= lix_pkg::ST_SATURATED;
      cross_x <= x_coord;
      cross_y <= y_coord;
    end else begin
      status  <= lix_pkg::ST_FOUND;
      cross_x <= x_coord;
      cross_y <= y_coord;
    end
  end

  // Every accepted item must come out as a result under done.
  a_latency: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##LAT done)
    else $error("accepted item did not produce a result on time");

  a_no_phantom: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start, LAT))
    else $error("result without a matching accepted item");

  // The two coordinate chains must stay in lockstep.
  a_lockstep: assert property (@(posedge clk) disable iff (rst)
    (x_ctl.valid == y_ctl.valid) && (!x_ctl.valid || (x_ctl.den_zero == y_ctl.den_zero)))
    else $error("coordinate pipelines out of step");

  a_sat_bound: assert property (@(posedge clk) disable iff (rst)
    (done && status == lix_pkg::ST_SATURATED) |->
      (cross_x == CRD_MAX || cross_x == CRD_MIN || cross_y == CRD_MAX || cross_y == CRD_MIN))
    else $error("saturated status without a coordinate at a bound");

endmodule
